// ----- sv/rwbr_pkg.sv -----
// ---------------------------------------------------------------------------
// rwbr_pkg - shared types and helpers for the rigid warp bilinear resampler
// Transaction payloads, register indexes, the per-item tag that travels down
// the pipeline, and the fixed-point rounding and saturation helpers.
// ---------------------------------------------------------------------------
package rwbr_pkg;

   // Request transaction payload
   typedef struct packed {
      logic               cmd;
      logic [7:0]         cell_row;
      logic [7:0]         cell_col;
      logic signed [31:0] source_height;
      logic               source_null;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic signed [31:0] warped_height;
      logic               warped_null;
   } rsp_type;

   // Register indexes on the write port
   typedef enum logic [2:0] {
      CSR_SIX_DOF_MODE  = 3'd0,
      CSR_GRID_DIMS     = 3'd1,
      CSR_CELL_SIZE     = 3'd2,
      CSR_SHIFT_XY      = 3'd3,
      CSR_SHIFT_Z       = 3'd4,
      CSR_YAW_SIN_COS   = 3'd5,
      CSR_ROLL_SIN_COS  = 3'd6,
      CSR_PITCH_SIN_COS = 3'd7
   } csr_index_type;

   // Command codes
   localparam logic CMD_WRITE    = 1'b0;
   localparam logic CMD_RESAMPLE = 1'b1;

   // Divider geometry: 8 integer quotient bits, 16 fraction bits
   localparam int DIV_INT_W  = 8;
   localparam int DIV_FRAC_W = 16;
   localparam int DIV_Q_W    = DIV_INT_W + DIV_FRAC_W;
   localparam int DIV_NUM_W  = 41;
   localparam int DIV_DEN_W  = 33;
   localparam int DIV_REM_W  = 42;

   // Per-item control and side data carried along the pipeline
   typedef struct packed {
      logic               valid;
      logic               cmd;
      logic [7:0]         row;
      logic [7:0]         col;
      logic signed [31:0] src_height;
      logic               src_null;
      logic               nul;
      logic signed [31:0] z2;
   } tag_type;

   // Clamp to +-(2^31-1)
   function automatic logic signed [31:0] sat31(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sd2147483647;
      end else if (v < -66'sd2147483647) begin
         r = -32'sd2147483647;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Q2.30 product sum back to Q16.16: add half, floor shift, clamp
   function automatic logic signed [31:0] rot_round(input logic signed [65:0] s);
      logic signed [65:0] t;
      t = (s + 66'sd536870912) >>> 30;
      return sat31(t);
   endfunction

   // Interpolation sum back to Q16.16: add half, floor shift
   function automatic logic signed [31:0] lerp_round(input logic signed [50:0] s);
      logic signed [50:0] t;
      t = (s + 51'sd32768) >>> 16;
      return t[31:0];
   endfunction

   // Full 32-bit signed saturation
   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -34'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/rwbr_div.sv -----
// ---------------------------------------------------------------------------
// rwbr_div - two-lane pipelined restoring divider
// One quotient bit per stage, 8 integer then 16 fraction bits, for the column
// and row lanes side by side. The user must keep the divisors steady while
// items are in flight; the block does not check. Tags leave with quotients.
// ---------------------------------------------------------------------------
module rwbr_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic [rwbr_pkg::DIV_NUM_W-1:0]    num_c,
   input  logic [rwbr_pkg::DIV_NUM_W-1:0]    num_r,
   input  logic [rwbr_pkg::DIV_DEN_W-1:0]    den_c,
   input  logic [rwbr_pkg::DIV_DEN_W-1:0]    den_r,
   input  rwbr_pkg::tag_type                 tag_in,
   output logic [rwbr_pkg::DIV_Q_W-1:0]      q_c,
   output logic [rwbr_pkg::DIV_Q_W-1:0]      q_r,
   output rwbr_pkg::tag_type                 tag_out
);
   import rwbr_pkg::*;

   logic [DIV_REM_W-1:0] rem_c_ff [DIV_Q_W];
   logic [DIV_REM_W-1:0] rem_r_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0]   quo_c_ff [DIV_Q_W];
   logic [DIV_Q_W-1:0]   quo_r_ff [DIV_Q_W];
   tag_type              tag_ff   [DIV_Q_W];

   for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
      logic [DIV_REM_W-1:0] rc_prev, rr_prev, rc_try, rr_try, dc_sh, dr_sh;
      logic [DIV_REM_W-1:0] rc_in, rr_in;
      logic [DIV_Q_W-1:0]   qc_prev, qr_prev, qc_in, qr_in;
      tag_type              tag_prev;

      // stage input
      if (k == 0) begin : g_first
         assign rc_prev  = DIV_REM_W'(num_c);
         assign rr_prev  = DIV_REM_W'(num_r);
         assign qc_prev  = '0;
         assign qr_prev  = '0;
         assign tag_prev = tag_in;
      end else begin : g_next
         assign rc_prev  = rem_c_ff[k-1];
         assign rr_prev  = rem_r_ff[k-1];
         assign qc_prev  = quo_c_ff[k-1];
         assign qr_prev  = quo_r_ff[k-1];
         assign tag_prev = tag_ff[k-1];
      end

      // integer bits compare against the shifted divisor, fraction bits
      // shift the remainder
      if (k < DIV_INT_W) begin : g_int
         assign rc_try = rc_prev;
         assign rr_try = rr_prev;
         assign dc_sh  = DIV_REM_W'(den_c) << (DIV_INT_W - 1 - k);
         assign dr_sh  = DIV_REM_W'(den_r) << (DIV_INT_W - 1 - k);
      end else begin : g_frac
         assign rc_try = rc_prev << 1;
         assign rr_try = rr_prev << 1;
         assign dc_sh  = DIV_REM_W'(den_c);
         assign dr_sh  = DIV_REM_W'(den_r);
      end

      // compare and subtract
      always_comb begin
         if (rc_try >= dc_sh) begin
            rc_in = rc_try - dc_sh;
            qc_in = {qc_prev[DIV_Q_W-2:0], 1'b1};
         end else begin
            rc_in = rc_try;
            qc_in = {qc_prev[DIV_Q_W-2:0], 1'b0};
         end
         if (rr_try >= dr_sh) begin
            rr_in = rr_try - dr_sh;
            qr_in = {qr_prev[DIV_Q_W-2:0], 1'b1};
         end else begin
            rr_in = rr_try;
            qr_in = {qr_prev[DIV_Q_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (en) begin
            tag_ff[k] <= tag_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_c_ff[k] <= rc_in;
            rem_r_ff[k] <= rr_in;
            quo_c_ff[k] <= qc_in;
            quo_r_ff[k] <= qr_in;
         end
      end
   end

   assign q_c     = quo_c_ff[DIV_Q_W-1];
   assign q_r     = quo_r_ff[DIV_Q_W-1];
   assign tag_out = tag_ff[DIV_Q_W-1];

endmodule

// ----- sv/rigid_warp_bilinear_resampler_top.sv -----
// ---------------------------------------------------------------------------
// rigid_warp_bilinear_resampler_top - inverse rigid warp with bilinear lookup
// Stores a source elevation grid with null marks and resamples target cells
// through the inverse of a yaw-only or pitch/roll/yaw rigid transform.
// ---------------------------------------------------------------------------
// One transaction is taken every clock cycle while the result is not stalled;
// a resample produces a result in the output register, a write command
// produces no result. A request passes the dx/dy stages, the three rotations,
// the 24-stage divider that turns rotated positions into grid indexes and
// weights, and the read and interpolation stages. The grid lives in four
// memories split by row and column parity, so the four neighbors are read in
// the same cycle; writes commit at that same read stage and so stay in order
// with resamples. The grid is not cleared after reset: read only written cells.
// When the result is stalled the whole pipeline holds. Registers may be
// written only while no transaction is in flight.
// ---------------------------------------------------------------------------
module rigid_warp_bilinear_resampler_top #(
   parameter int MAX_ROWS = 256,
   parameter int MAX_COLS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rwbr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rwbr_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata
);
   import rwbr_pkg::*;

   localparam int ROWS_EFF   = (MAX_ROWS < 256) ? MAX_ROWS : 256;
   localparam int COLS_EFF   = (MAX_COLS < 256) ? MAX_COLS : 256;
   localparam int RA         = (ROWS_EFF > 2) ? $clog2(ROWS_EFF) - 1 : 1;
   localparam int CA         = (COLS_EFF > 2) ? $clog2(COLS_EFF) - 1 : 1;
   localparam int BANK_DEPTH = 2 ** (RA + CA);
   localparam int FRONT_N    = 10;
   localparam int TAIL_N     = 5;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic        six_dof_ff;
   logic [15:0] grid_dims_ff;
   logic [63:0] cell_size_ff, shift_xy_ff, yaw_ff, roll_ff, pitch_ff;
   logic [31:0] shift_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         six_dof_ff   <= 1'b0;
         grid_dims_ff <= 16'hffff;
         cell_size_ff <= 64'h0001_0000_0001_0000;
         shift_xy_ff  <= '0;
         shift_z_ff   <= '0;
         yaw_ff       <= 64'h0000_0000_4000_0000;
         roll_ff      <= 64'h0000_0000_4000_0000;
         pitch_ff     <= 64'h0000_0000_4000_0000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SIX_DOF_MODE:  six_dof_ff   <= csr_wdata[0];
            CSR_GRID_DIMS:     grid_dims_ff <= csr_wdata[15:0];
            CSR_CELL_SIZE:     cell_size_ff <= csr_wdata;
            CSR_SHIFT_XY:      shift_xy_ff  <= csr_wdata;
            CSR_SHIFT_Z:       shift_z_ff   <= csr_wdata[31:0];
            CSR_YAW_SIN_COS:   yaw_ff       <= csr_wdata;
            CSR_ROLL_SIN_COS:  roll_ff      <= csr_wdata;
            CSR_PITCH_SIN_COS: pitch_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Grid geometry seen by the arithmetic
   logic [8:0]         rows_raw, cols_raw, rows_w, cols_w;
   logic [31:0]        ew, ns;
   logic signed [32:0] ews, nss;
   logic signed [31:0] tx, ty, tz;
   logic signed [32:0] cy, sy, nsy, cr, sr, nsr, cp, sp;
   logic [39:0]        cew_in, rns_in, cew_ff, rns_ff;

   assign rows_raw = 9'(grid_dims_ff[15:8]) + 9'd1;
   assign cols_raw = 9'(grid_dims_ff[7:0]) + 9'd1;
   assign rows_w   = (32'(rows_raw) > MAX_ROWS) ? 9'(MAX_ROWS) : rows_raw;
   assign cols_w   = (32'(cols_raw) > MAX_COLS) ? 9'(MAX_COLS) : cols_raw;
   assign ew       = cell_size_ff[63:32];
   assign ns       = cell_size_ff[31:0];
   assign ews      = signed'({1'b0, ew});
   assign nss      = signed'({1'b0, ns});
   assign tx       = signed'(shift_xy_ff[63:32]);
   assign ty       = signed'(shift_xy_ff[31:0]);
   assign tz       = signed'(shift_z_ff);
   assign cy       = 33'(signed'(yaw_ff[31:0]));
   assign sy       = 33'(signed'(yaw_ff[63:32]));
   assign cr       = 33'(signed'(roll_ff[31:0]));
   assign sr       = 33'(signed'(roll_ff[63:32]));
   assign cp       = 33'(signed'(pitch_ff[31:0]));
   assign sp       = 33'(signed'(pitch_ff[63:32]));
   assign nsy      = -sy;
   assign nsr      = -sr;

   // Grid span products, only config dependent
   assign cew_in = 40'(cols_w - 9'd1) * 40'(ew);
   assign rns_in = 40'(rows_w - 9'd1) * 40'(ns);

   always_ff @(posedge clock) begin
      cew_ff <= cew_in;
      rns_ff <= rns_in;
   end

   // ------------------------------------------------------------------
   // Flow control: the whole pipeline moves unless the result is stalled
   // ------------------------------------------------------------------
   logic en, accept;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;
   assign accept    = req_valid && en;

   // ------------------------------------------------------------------
   // Front tag pipeline (stages 0 to 9)
   // ------------------------------------------------------------------
   tag_type            tag_ff [FRONT_N];
   tag_type            tag_in [FRONT_N];
   logic signed [31:0] z2_in;
   logic               nul9_in;

   always_comb begin
      tag_in[0]            = '0;
      tag_in[0].valid      = accept;
      tag_in[0].cmd        = req_data.cmd;
      tag_in[0].row        = req_data.cell_row;
      tag_in[0].col        = req_data.cell_col;
      tag_in[0].src_height = req_data.source_height;
      tag_in[0].src_null   = req_data.source_null;
      for (int i = 1; i < FRONT_N; i++) begin
         tag_in[i] = tag_ff[i-1];
      end
      tag_in[6].z2  = z2_in;
      tag_in[9].nul = nul9_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRONT_N; i++) begin
            tag_ff[i] <= '0;
         end
      end else if (en) begin
         for (int i = 0; i < FRONT_N; i++) begin
            tag_ff[i] <= tag_in[i];
         end
      end
   end

   // Stage 1: cell center offsets times resolution
   logic signed [10:0] mxk_in, myk_in;
   logic signed [43:0] mx_in, my_in, mx_ff, my_ff;

   assign mxk_in = signed'({2'b00, tag_ff[0].col, 1'b1}) - signed'({2'b00, cols_w});
   assign myk_in = signed'({2'b00, rows_w}) - signed'({2'b00, tag_ff[0].row, 1'b1});
   assign mx_in  = mxk_in * ews;
   assign my_in  = myk_in * nss;

   // Stage 2: remove shift, halve with round-half-up, clamp
   logic signed [65:0] dx_sum, dy_sum;
   logic signed [31:0] dx_in, dy_in, dx_ff, dy_ff;

   assign dx_sum = 66'(mx_ff) - (66'(tx) <<< 1) + 66'sd1;
   assign dy_sum = 66'(my_ff) - (66'(ty) <<< 1) + 66'sd1;
   assign dx_in  = sat31(dx_sum >>> 1);
   assign dy_in  = sat31(dy_sum >>> 1);

   // Stage 3: pitch products
   logic signed [64:0] p3a_in, p3b_in, p3a_ff, p3b_ff;
   logic signed [31:0] dx3_ff, dy3_ff;

   assign p3a_in = dx_ff * cp;
   assign p3b_in = dx_ff * sp;

   // Stage 4: undo pitch (yaw-only passes dx through)
   logic signed [31:0] x1_in, z1_in, x1_ff, z1_ff, dy4_ff;

   assign x1_in = six_dof_ff ? rot_round(66'(p3a_ff)) : dx3_ff;
   assign z1_in = rot_round(66'(p3b_ff));

   // Stage 5: roll products
   logic signed [64:0] p5a_in, p5b_in, p5c_in, p5d_in;
   logic signed [64:0] p5a_ff, p5b_ff, p5c_ff, p5d_ff;
   logic signed [31:0] x15_ff, dy5_ff;

   assign p5a_in = dy4_ff * cr;
   assign p5b_in = z1_ff * sr;
   assign p5c_in = dy4_ff * nsr;
   assign p5d_in = z1_ff * cr;

   // Stage 6: undo roll (yaw-only passes dy through, no height term)
   logic signed [31:0] y2_in, y2_ff, x16_ff;

   assign y2_in = six_dof_ff ? rot_round(66'(p5a_ff) + 66'(p5b_ff)) : dy5_ff;
   assign z2_in = six_dof_ff ? rot_round(66'(p5c_ff) + 66'(p5d_ff)) : 32'sd0;

   // Stage 7: yaw products
   logic signed [64:0] p7a_in, p7b_in, p7c_in, p7d_in;
   logic signed [64:0] p7a_ff, p7b_ff, p7c_ff, p7d_ff;

   assign p7a_in = x16_ff * cy;
   assign p7b_in = y2_ff * sy;
   assign p7c_in = x16_ff * nsy;
   assign p7d_in = y2_ff * cy;

   // Stage 8: undo yaw
   logic signed [31:0] xr_in, yr_in, xr_ff, yr_ff;

   assign xr_in = rot_round(66'(p7a_ff) + 66'(p7b_ff));
   assign yr_in = rot_round(66'(p7c_ff) + 66'(p7d_ff));

   // Stage 9: divider numerators and range check
   logic signed [41:0]     numc_s, numr_s;
   logic [DIV_NUM_W-1:0]   numc_ff, numr_ff;

   assign numc_s  = (42'(xr_ff) <<< 1) + signed'({2'b00, cew_ff});
   assign numr_s  = signed'({2'b00, rns_ff}) - (42'(yr_ff) <<< 1);
   assign nul9_in = (ew == '0) || (ns == '0)
                 || (numc_s < 42'sd0) || (numc_s >= signed'({1'b0, cew_ff, 1'b0}))
                 || (numr_s < 42'sd0) || (numr_s >= signed'({1'b0, rns_ff, 1'b0}));

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         p3a_ff  <= p3a_in;
         p3b_ff  <= p3b_in;
         dx3_ff  <= dx_ff;
         dy3_ff  <= dy_ff;
         x1_ff   <= x1_in;
         z1_ff   <= z1_in;
         dy4_ff  <= dy3_ff;
         p5a_ff  <= p5a_in;
         p5b_ff  <= p5b_in;
         p5c_ff  <= p5c_in;
         p5d_ff  <= p5d_in;
         x15_ff  <= x1_ff;
         dy5_ff  <= dy4_ff;
         y2_ff   <= y2_in;
         x16_ff  <= x15_ff;
         p7a_ff  <= p7a_in;
         p7b_ff  <= p7b_in;
         p7c_ff  <= p7c_in;
         p7d_ff  <= p7d_in;
         xr_ff   <= xr_in;
         yr_ff   <= yr_in;
         numc_ff <= numc_s[DIV_NUM_W-1:0];
         numr_ff <= numr_s[DIV_NUM_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Index and weight division
   // ------------------------------------------------------------------
   logic [DIV_Q_W-1:0] qc, qr;
   tag_type            tag_d;

   rwbr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .num_c   (numc_ff),
      .num_r   (numr_ff),
      .den_c   ({ew, 1'b0}),
      .den_r   ({ns, 1'b0}),
      .tag_in  (tag_ff[FRONT_N-1]),
      .q_c     (qc),
      .q_r     (qr),
      .tag_out (tag_d)
   );

   logic [7:0]  c0, r0;
   logic [15:0] u_w, v_w;

   assign c0  = qc[DIV_Q_W-1:DIV_FRAC_W];
   assign u_w = qc[DIV_FRAC_W-1:0];
   assign r0  = qr[DIV_Q_W-1:DIV_FRAC_W];
   assign v_w = qr[DIV_FRAC_W-1:0];

   // ------------------------------------------------------------------
   // Grid memories, banked by row and column parity
   // ------------------------------------------------------------------
   logic [32:0] bank_rd_ff [4];
   logic        wr_ok;

   assign wr_ok = tag_d.valid && (tag_d.cmd == CMD_WRITE)
               && (32'(tag_d.row) < MAX_ROWS) && (32'(tag_d.col) < MAX_COLS);

   for (genvar bi = 0; bi < 4; bi++) begin : g_bank
      localparam logic RP = 1'(bi >> 1);
      localparam logic CP = 1'(bi & 1);
      logic [32:0]      mem [BANK_DEPTH];
      logic [8:0]       rd_row, rd_col;
      logic [RA+CA-1:0] rd_addr, wr_addr;
      logic             wr_en;

      // the neighbor row/column of this parity
      assign rd_row  = {1'b0, r0} + 9'(r0[0] ^ RP);
      assign rd_col  = {1'b0, c0} + 9'(c0[0] ^ CP);
      assign rd_addr = {rd_row[RA:1], rd_col[CA:1]};
      assign wr_addr = {tag_d.row[RA:1], tag_d.col[CA:1]};
      assign wr_en   = en && wr_ok && (tag_d.row[0] == RP) && (tag_d.col[0] == CP);

      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= {tag_d.src_null, tag_d.src_height};
         end
         if (en) begin
            bank_rd_ff[bi] <= mem[rd_addr];
         end
      end
   end

   // ------------------------------------------------------------------
   // Tail tag pipeline (read, lerp stages)
   // ------------------------------------------------------------------
   tag_type tail_ff [TAIL_N];
   tag_type tail_in [TAIL_N];
   logic    nb_null;

   always_comb begin
      tail_in[0] = tag_d;
      for (int i = 1; i < TAIL_N; i++) begin
         tail_in[i] = tail_ff[i-1];
      end
      tail_in[1].nul = tail_ff[0].nul | nb_null;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAIL_N; i++) begin
            tail_ff[i] <= '0;
         end
      end else if (en) begin
         for (int i = 0; i < TAIL_N; i++) begin
            tail_ff[i] <= tail_in[i];
         end
      end
   end

   // Neighbor selection from parity banks
   logic        rp_ff, cp_ff;
   logic [15:0] um_ff, vm_ff, v1_ff, v2_ff;
   logic [32:0] lo_a, lo_b, hi_a, hi_b, n00, n10, n01, n11;

   assign lo_a    = cp_ff ? bank_rd_ff[1] : bank_rd_ff[0];
   assign lo_b    = cp_ff ? bank_rd_ff[0] : bank_rd_ff[1];
   assign hi_a    = cp_ff ? bank_rd_ff[3] : bank_rd_ff[2];
   assign hi_b    = cp_ff ? bank_rd_ff[2] : bank_rd_ff[3];
   assign n00     = rp_ff ? hi_a : lo_a;
   assign n10     = rp_ff ? hi_b : lo_b;
   assign n01     = rp_ff ? lo_a : hi_a;
   assign n11     = rp_ff ? lo_b : hi_b;
   assign nb_null = n00[32] | n10[32] | n01[32] | n11[32];

   // L1: horizontal weight products
   logic [16:0]        wu0, wv0;
   logic signed [17:0] wu0_s, wu1_s, wv0_s, wv1_s;
   logic signed [49:0] pa0_in, pa1_in, pb0_in, pb1_in;
   logic signed [49:0] pa0_ff, pa1_ff, pb0_ff, pb1_ff;

   assign wu0    = 17'h10000 - 17'(um_ff);
   assign wu0_s  = signed'({1'b0, wu0});
   assign wu1_s  = signed'({2'b00, um_ff});
   assign pa0_in = wu0_s * signed'(n00[31:0]);
   assign pa1_in = wu1_s * signed'(n10[31:0]);
   assign pb0_in = wu0_s * signed'(n01[31:0]);
   assign pb1_in = wu1_s * signed'(n11[31:0]);

   // L2: horizontal lerp results
   logic signed [31:0] a_in, b_in, a_ff, b_ff;

   assign a_in = lerp_round(51'(pa0_ff) + 51'(pa1_ff));
   assign b_in = lerp_round(51'(pb0_ff) + 51'(pb1_ff));

   // L3: vertical weight products
   logic signed [49:0] pc0_in, pc1_in, pc0_ff, pc1_ff;

   assign wv0    = 17'h10000 - 17'(v2_ff);
   assign wv0_s  = signed'({1'b0, wv0});
   assign wv1_s  = signed'({2'b00, v2_ff});
   assign pc0_in = wv0_s * a_ff;
   assign pc1_in = wv1_s * b_ff;

   // L4: vertical lerp
   logic signed [31:0] s_in, s_ff;

   assign s_in = lerp_round(51'(pc0_ff) + 51'(pc1_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         rp_ff  <= r0[0];
         cp_ff  <= c0[0];
         um_ff  <= u_w;
         vm_ff  <= v_w;
         v1_ff  <= vm_ff;
         v2_ff  <= v1_ff;
         pa0_ff <= pa0_in;
         pa1_ff <= pa1_in;
         pb0_ff <= pb0_in;
         pb1_ff <= pb1_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
         pc0_ff <= pc0_in;
         pc1_ff <= pc1_in;
         s_ff   <= s_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register: add vertical shift and height term, saturate
   // ------------------------------------------------------------------
   logic signed [33:0] res_sum;
   logic               rsp_valid_in, rsp_valid_ff;
   rsp_type            rsp_in, rsp_ff;

   assign res_sum      = 34'(s_ff) + 34'(tz) + 34'(tail_ff[TAIL_N-1].z2);
   assign rsp_valid_in = tail_ff[TAIL_N-1].valid && (tail_ff[TAIL_N-1].cmd == CMD_RESAMPLE);

   always_comb begin
      rsp_in.warped_null   = tail_ff[TAIL_N-1].nul;
      rsp_in.warped_height = tail_ff[TAIL_N-1].nul ? 32'sd0 : sat32(res_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- sv/rwbr_checker.sv -----
// ---------------------------------------------------------------------------
// rwbr_checker - port-level checks for the resampler
// Watches the handshakes and result payload of the top level over time.
// ---------------------------------------------------------------------------
module rwbr_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rwbr_pkg::rsp_type rsp_data
);
   import rwbr_pkg::*;

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input backpressure only comes from a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without result backpressure");

   // null results carry zero height
   a_null_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.warped_null |-> rsp_data.warped_height == 32'sd0)
      else $error("null result with nonzero height");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a waiting request sees flow while the result side is not stalled
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_stall |-> !req_stall)
      else $error("request stalled while result side is open");

endmodule

bind rigid_warp_bilinear_resampler_top rwbr_checker u_rwbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - rigid warp bilinear resampler checks
// Fills small source grids, resamples target cells under several warp and
// grid settings and checks every result against the plan or a predictor.
// ---------------------------------------------------------------------------
module testbench;
   import rwbr_pkg::*;

   localparam longint LIM31       = 64'sd2147483647;
   localparam int     DRAIN_WAIT  = 45;
   localparam int     CYCLE_LIMIT = 600000;
   localparam int     PER_PHASE   = 44;
   localparam int     LAST_PHASE  = 9;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   rsp_type       rsp_data;
   logic          csr_we;
   logic [2:0]    csr_index;
   logic [63:0]   csr_wdata;

   // Register shadows
   logic          six_dof;
   logic [15:0]   dims;
   logic [63:0]   res_xy;
   logic [63:0]   shift_xy;
   logic [31:0]   shift_z;
   logic [63:0]   yaw_sc;
   logic [63:0]   roll_sc;
   logic [63:0]   pitch_sc;

   // Source grid copy
   logic signed [31:0] elev_mem [65536];
   bit                 null_mem [65536];
   bit                 filled   [65536];

   rsp_type pending_results[$];
   int      errors;
   int      cycles;
   bit      quiet;
   int      stall_left;

   // Directed stimulus row
   typedef struct {
      logic        cmd;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [31:0] height;
      logic        nul;
      bit          typed;
      logic [31:0] exp_height;
      logic        exp_null;
   } directed_row_type;

   directed_row_type plan[] = '{
      '{CMD_WRITE, 8'd0, 8'd0, 32'h7fffffff, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd0, 8'd1, 32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd0, 8'd2, 32'h00000000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd1, 8'd0, 32'h00010000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd1, 8'd1, 32'h12345678, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd1, 8'd2, 32'hfffffffb, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd2, 8'd0, 32'hffffffff, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd2, 8'd1, 32'h5555aaaa, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd2, 8'd2, 32'h00000000, 1'b1, 1'b0, 32'h0, 1'b0},
      '{CMD_RESAMPLE, 8'd0, 8'd0, 32'h0, 1'b0, 1'b1, 32'h7fffffff, 1'b0},
      '{CMD_RESAMPLE, 8'd1, 8'd1, 32'h0, 1'b0, 1'b1, 32'h0, 1'b1},
      '{CMD_RESAMPLE, 8'd2, 8'd2, 32'h0, 1'b0, 1'b1, 32'h0, 1'b1},
      '{CMD_RESAMPLE, 8'd200, 8'd3, 32'h0, 1'b0, 1'b1, 32'h0, 1'b1},
      '{CMD_RESAMPLE, 8'd255, 8'd255, 32'h0, 1'b0, 1'b1, 32'h0, 1'b1},
      '{CMD_RESAMPLE, 8'd0, 8'd1, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_RESAMPLE, 8'd1, 8'd0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_WRITE, 8'd0, 8'd0, 32'h80000000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{CMD_RESAMPLE, 8'd0, 8'd0, 32'h0, 1'b0, 1'b1, 32'h80000000, 1'b0},
      '{CMD_RESAMPLE, 8'd0, 8'd2, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0}
   };

   rigid_warp_bilinear_resampler_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic longint sx32(input logic [31:0] v);
      logic signed [31:0] t;
      t = v;
      return t;
   endfunction

   function automatic longint clamp31(input longint v);
      return v > LIM31 ? LIM31 : (v < -LIM31 ? -LIM31 : v);
   endfunction

   // Q2.30 weighted sum back to Q16.16, round half up, clamp
   function automatic longint turn(input longint a, input longint ka,
                                   input longint b, input longint kb);
      logic signed [95:0] wa, wka, wb, wkb, s;
      wa  = 96'(a);
      wka = 96'(ka);
      wb  = 96'(b);
      wkb = 96'(kb);
      s = (wa * wka + wb * wkb + 96'sd536870912) >>> 30;
      if (s > 96'sd2147483647) s = 96'sd2147483647;
      if (s < -96'sd2147483647) s = -96'sd2147483647;
      return s[63:0];
   endfunction

   function automatic void floor_div(input longint num, input longint den,
                                     output longint q, output longint rm);
      q  = num / den;
      rm = num % den;
      if (rm < 0) begin
         q--;
         rm += den;
      end
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint w);
      return ((65536 - w) * a + w * b + 32768) >>> 16;
   endfunction

   // Inverse warp of a target cell into the source grid; 1 when the
   // bilinear footprint lies fully inside the grid
   function automatic bit locate(input logic [7:0] row, input logic [7:0] col,
                                 output longint r0, output longint c0,
                                 output longint u, output longint v,
                                 output longint z2);
      longint rows, cols, ew, ns, dx, dy, xr, yr, sy, cy, sr, cr, sp, cp;
      longint x1, z1, y2, num, rm;
      rows = longint'(dims[15:8]) + 1;
      cols = longint'(dims[7:0]) + 1;
      ew   = longint'(res_xy[63:32]);
      ns   = longint'(res_xy[31:0]);
      dx = clamp31(((2 * longint'(col) + 1 - cols) * ew - 2 * sx32(shift_xy[63:32]) + 1)
                   >>> 1);
      dy = clamp31(((rows - 2 * longint'(row) - 1) * ns - 2 * sx32(shift_xy[31:0]) + 1)
                   >>> 1);
      sy = sx32(yaw_sc[63:32]);
      cy = sx32(yaw_sc[31:0]);
      z2 = 0;
      r0 = 0;
      c0 = 0;
      u  = 0;
      v  = 0;
      if (six_dof) begin
         sr = sx32(roll_sc[63:32]);
         cr = sx32(roll_sc[31:0]);
         sp = sx32(pitch_sc[63:32]);
         cp = sx32(pitch_sc[31:0]);
         x1 = turn(dx, cp, 0, 0);
         z1 = turn(dx, sp, 0, 0);
         y2 = turn(dy, cr, z1, sr);
         z2 = turn(dy, -sr, z1, cr);
         xr = turn(x1, cy, y2, sy);
         yr = turn(x1, -sy, y2, cy);
      end else begin
         xr = turn(dx, cy, dy, sy);
         yr = turn(dx, -sy, dy, cy);
      end
      if (ew == 0 || ns == 0) return 1'b0;
      num = 2 * xr + (cols - 1) * ew;
      floor_div(num, 2 * ew, c0, rm);
      u = (rm * 65536) / (2 * ew);
      num = (rows - 1) * ns - 2 * yr;
      floor_div(num, 2 * ns, r0, rm);
      v = (rm * 65536) / (2 * ns);
      return !(c0 < 0 || r0 < 0 || c0 + 1 >= cols || r0 + 1 >= rows);
   endfunction

   function automatic rsp_type predict_warp(input logic [7:0] row, input logic [7:0] col);
      longint  r0, c0, u, v, z2, a, b, s;
      int      i;
      rsp_type o;
      o = '0;
      o.warped_null = 1'b1;
      if (locate(row, col, r0, c0, u, v, z2)) begin
         i = int'(r0) * 256 + int'(c0);
         if (!(null_mem[i] | null_mem[i + 1] | null_mem[i + 256] | null_mem[i + 257])) begin
            a = blend(elev_mem[i], elev_mem[i + 1], u);
            b = blend(elev_mem[i + 256], elev_mem[i + 257], u);
            s = blend(a, b, v) + sx32(shift_z) + z2;
            if (s > LIM31) s = LIM31;
            if (s < -LIM31 - 1) s = -LIM31 - 1;
            o.warped_height = s[31:0];
            o.warped_null   = 1'b0;
         end
      end
      return o;
   endfunction

   // Update the grid copy or queue the expected result of one transaction
   function automatic void commit(input req_type t, input bit typed, input rsp_type exp);
      int i;
      i = int'(t.cell_row) * 256 + int'(t.cell_col);
      if (t.cmd == CMD_WRITE) begin
         elev_mem[i] = t.source_height;
         null_mem[i] = t.source_null;
         filled[i]   = 1'b1;
      end else begin
         pending_results.push_back(typed ? exp : predict_warp(t.cell_row, t.cell_col));
      end
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   task automatic send(input req_type t, input bit typed, input rsp_type exp);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (req_stall);
      commit(t, typed, exp);
   endtask

   task automatic send_plain(input req_type t);
      send(t, 1'b0, '0);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [63:0] d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_SIX_DOF_MODE:  six_dof  = d[0];
         CSR_GRID_DIMS:     dims     = d[15:0];
         CSR_CELL_SIZE:     res_xy   = d;
         CSR_SHIFT_XY:      shift_xy = d;
         CSR_SHIFT_Z:       shift_z  = d[31:0];
         CSR_YAW_SIN_COS:   yaw_sc   = d;
         CSR_ROLL_SIN_COS:  roll_sc  = d;
         CSR_PITCH_SIN_COS: pitch_sc = d;
         default: ;
      endcase
   endtask

   function automatic logic [63:0] rand_trig();
      real ang;
      int  s, c;
      ang = $urandom_range(0, 62831) / 10000.0;
      s = $rtoi($sin(ang) * 1073741824.0);
      c = $rtoi($cos(ang) * 1073741824.0);
      return {s[31:0], c[31:0]};
   endfunction

   function automatic logic [31:0] rand_res();
      return $urandom_range(16384, 4 * 65536);
   endfunction

   function automatic logic [31:0] rand_shift();
      int s;
      s = int'($urandom_range(0, 8 * 65536)) - 4 * 65536;
      return s;
   endfunction

   // Program every register for one phase
   task automatic program_phase(input int p);
      logic [63:0] mode, gd, cs, sxy, sz, yw, rl, pt;
      mode = 64'($urandom_range(0, 1));
      gd   = {48'h0, 8'($urandom_range(1, 7)), 8'($urandom_range(1, 7))};
      cs   = {rand_res(), rand_res()};
      sxy  = {rand_shift(), rand_shift()};
      sz   = {32'h0, rand_shift()};
      yw   = rand_trig();
      rl   = rand_trig();
      pt   = rand_trig();
      case (p)
         0: begin
            mode = 64'd0; gd = 64'h0202; cs = 64'h0001_0000_0001_0000;
            sxy = '0; sz = '0; yw = 64'h4000_0000; rl = yw; pt = yw;
         end
         1: begin
            mode = 64'd0; cs = 64'h0001_0000_0001_0000; sxy = '0;
            yw = 64'h4000_0000;
         end
         2: mode = 64'd0;
         3: mode = 64'd1;
         4: begin
            cs = ($urandom_range(0, 1) != 0) ? {32'h0, rand_res()} : {rand_res(), 32'h0};
            yw = 64'h8000_0000_7fff_ffff; rl = 64'h7fff_ffff_8000_0000;
            pt = 64'hffff_ffff_ffff_ffff; sz = 64'h8000_0000; mode = 64'd1;
         end
         5: begin
            mode = 64'd1; sz = 64'h7fff_ffff; sxy = 64'h7fff_ffff_8000_0000;
            yw = {$urandom, $urandom}; rl = {$urandom, $urandom}; pt = {$urandom, $urandom};
         end
         6: begin
            gd = 64'hffff; cs = {32'h8000 + $urandom_range(0, 65536), 32'h10000};
         end
         7: gd = 64'h0000;
         8: begin
            mode = 64'd1; cs = {$urandom, $urandom}; sz = {32'h0, $urandom};
         end
         default: ;
      endcase
      csr_put(CSR_SIX_DOF_MODE, mode);
      csr_put(CSR_GRID_DIMS, gd);
      csr_put(CSR_CELL_SIZE, cs);
      csr_put(CSR_SHIFT_XY, sxy);
      csr_put(CSR_SHIFT_Z, sz);
      csr_put(CSR_YAW_SIN_COS, yw);
      csr_put(CSR_ROLL_SIN_COS, rl);
      csr_put(CSR_PITCH_SIN_COS, pt);
   endtask

   function automatic req_type rand_write(input int r, input int c, input int null_pct);
      req_type t;
      t.cmd           = CMD_WRITE;
      t.cell_row      = 8'(r);
      t.cell_col      = 8'(c);
      t.source_height = ($urandom_range(0, 1) != 0) ? $urandom : rand_shift();
      t.source_null   = ($urandom_range(0, 99) < null_pct);
      return t;
   endfunction

   // Random transactions; a resample whose footprint holds unwritten cells
   // gets those cells written first
   task automatic random_phase(input int p);
      req_type t;
      int      rows, cols;
      longint  r0, c0, u, v, z2;
      rows = int'(dims[15:8]) + 1;
      cols = int'(dims[7:0]) + 1;
      for (int k = 0; k < PER_PHASE; k++) begin
         if (p == 2 && k == PER_PHASE / 2) begin
            // hold the sender until the pipeline is empty
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 4) == 0) begin
               send_plain(rand_write($urandom_range(0, 255), $urandom_range(0, 255), 10));
            end else begin
               send_plain(rand_write($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                                     10));
            end
         end else begin
            t = '0;
            t.cmd = CMD_RESAMPLE;
            if ($urandom_range(0, 9) == 0) begin
               t.cell_row = 8'($urandom_range(0, 255));
               t.cell_col = 8'($urandom_range(0, 255));
            end else begin
               t.cell_row = 8'($urandom_range(0, rows));
               t.cell_col = 8'($urandom_range(0, cols));
            end
            t.source_height = $urandom;
            t.source_null   = 1'($urandom_range(0, 1));
            if (locate(t.cell_row, t.cell_col, r0, c0, u, v, z2)) begin
               for (int dr = 0; dr < 2; dr++) begin
                  for (int dc = 0; dc < 2; dc++) begin
                     if (!filled[(int'(r0) + dr) * 256 + int'(c0) + dc]) begin
                        send_plain(rand_write(int'(r0) + dr, int'(c0) + dc, 5));
                     end
                  end
               end
            end
            send_plain(t);
         end
      end
   endtask

   // Result stall in random bursts
   always @(negedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction: height %h null %b",
                   rsp_data.warped_height, rsp_data.warped_null);
            errors++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_data.warped_height !== exp.warped_height) begin
               $error("warped_height: expected %h, actual %h",
                      exp.warped_height, rsp_data.warped_height);
               errors++;
            end
            if (rsp_data.warped_null !== exp.warped_null) begin
               $error("warped_null: expected %b, actual %b",
                      exp.warped_null, rsp_data.warped_null);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      req_type t;
      rsp_type exp;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_stall  = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      reset      = 1'b1;
      errors     = 0;
      cycles     = 0;
      quiet      = 1'b0;
      stall_left = 0;
      six_dof    = 1'b0;
      dims       = 16'hffff;
      res_xy     = 64'h0001_0000_0001_0000;
      shift_xy   = '0;
      shift_z    = '0;
      yaw_sc     = 64'h4000_0000;
      roll_sc    = 64'h4000_0000;
      pitch_sc   = 64'h4000_0000;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part on a 3x3 grid
      program_phase(0);
      foreach (plan[n]) begin
         t.cmd               = plan[n].cmd;
         t.cell_row          = plan[n].row;
         t.cell_col          = plan[n].col;
         t.source_height     = plan[n].height;
         t.source_null       = plan[n].nul;
         exp.warped_height   = plan[n].exp_height;
         exp.warped_null     = plan[n].exp_null;
         send(t, plan[n].typed, exp);
      end
      drain();

      // Random phases under changing settings
      for (int p = 1; p <= LAST_PHASE; p++) begin
         quiet = (p == LAST_PHASE);
         program_phase(p);
         random_phase(p);
         drain();
      end

      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/rwbr_pkg.sv
sv/rwbr_div.sv
sv/rigid_warp_bilinear_resampler_top.sv
sv/rwbr_checker.sv
dv/testbench.sv
